// File: sv/mlfq_scheduler_core_defines.svh
// Assertion macros for the feedback-queue scheduler.
// Included by the top level; needs clk and rst_n in scope.
`ifndef MLFQ_SCHEDULER_CORE_DEFINES_SVH
`define MLFQ_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mlfq check failed");
`define MLFQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mlfq check failed");
`else
`define MLFQ_ASSERT_NOW(lbl, pre, post)
`define MLFQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: sv/mlfq_pkg.sv
// Shared types and constants of the feedback-queue scheduler.
// No dependencies.
package mlfq_pkg;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LVL_W     = 3;
    localparam int ID_W      = 16;
    localparam int LEN_W     = 16;
    localparam int SLICE_W   = 8;
    localparam int TIME_W    = 32;
    localparam int QT_W      = 40;
    localparam int AT_W      = 64;
    localparam int BP_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd2;

    localparam logic [QT_W-1:0] QUANTUM_RST = 40'd86151661573;
    localparam logic [AT_W-1:0] ALLOT_RST   = 64'd21110795053563914;
    localparam logic [BP_W-1:0] PERIOD_RST  = 16'd40;

    typedef enum logic [1:0] {
        ST_ADMIT  = 2'd0,
        ST_RAN    = 2'd1,
        ST_IDLE   = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef struct packed {
        logic take;
        logic admit;
        logic sel;
        logic slot;
        logic exec;
        logic brd;
        logic bwr;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic any_q;
        logic hit;
        logic bmore;
        logic out_free;
    } sts_t;
endpackage

// File: sv/mlfq_in_if.sv
// Input channel of the scheduler: command items.
// Uses no package.
interface mlfq_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] job_id;
    logic [15:0] job_length;

    modport source (output valid, command, job_id, job_length, input ready);
    modport sink (input valid, command, job_id, job_length, output ready);
endinterface

// File: sv/mlfq_out_if.sv
// Output channel of the scheduler: result items.
// Uses no package.
interface mlfq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] run_id;
    logic [2:0]  run_level;
    logic [7:0]  slice_time;
    logic [15:0] remaining;
    logic [31:0] elapsed;
    logic        finished;
    logic        demoted;
    logic        boosted;

    modport source (output valid, status, run_id, run_level, slice_time, remaining,
                    elapsed, finished, demoted, boosted, input ready);
    modport sink (input valid, status, run_id, run_level, slice_time, remaining,
                  elapsed, finished, demoted, boosted, output ready);
endinterface

// File: sv/mlfq_scheduler_core.sv
// Admit/reject: IDLE, ADMIT, DONE; idle run: IDLE, SEL, DONE; the result is loaded on leaving DONE.
// Run: IDLE, SEL, SLOT, EXEC, DONE (queue RAM read, then job RAM read);
// a boost adds a BRD check plus a BRD, BWR pair per job moved.
// The output register lets the next item be accepted while a result waits; DONE stalls
// while it is held. Reset: async active low; queues empty, all slots free, timer and
// boost count zero, config registers at their defaults. No clearing pass.
module mlfq_scheduler_core #(
    parameter int LEVELS = 5,
    parameter int JOBS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mlfq_in_if.sink                        req,
    mlfq_out_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]     cfg_data
);
    import mlfq_pkg::*;
    `include "mlfq_scheduler_core_defines.svh"

    cmd_t cmd;
    sts_t sts;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mlfq_dp #(.LEVELS(LEVELS), .JOBS(JOBS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_command    (req.command),
        .req_job_id     (req.job_id),
        .req_job_length (req.job_length),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp.status),
        .rsp_run_id     (rsp.run_id),
        .rsp_run_level  (rsp.run_level),
        .rsp_slice_time (rsp.slice_time),
        .rsp_remaining  (rsp.remaining),
        .rsp_elapsed    (rsp.elapsed),
        .rsp_finished   (rsp.finished),
        .rsp_demoted    (rsp.demoted),
        .rsp_boosted    (rsp.boosted)
    );

    `MLFQ_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready)
    `MLFQ_ASSERT_NOW(a_idle_quiet, rsp.valid && rsp.status == ST_IDLE, rsp.slice_time == '0 && !rsp.finished && !rsp.boosted)
    `MLFQ_ASSERT_NOW(a_fin_done, rsp.valid && rsp.finished, rsp.remaining == '0 && rsp.status == ST_RAN)
    `MLFQ_ASSERT_NOW(a_dem_alive, rsp.valid && rsp.demoted, !rsp.finished && rsp.remaining != '0)
endmodule

// File: sv/mlfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/mlfq_ctrl.sv
// Sequencer of the scheduler: one item at a time, boost as a move loop.
// Depends on mlfq_pkg.
module mlfq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mlfq_pkg::sts_t sts,
    output mlfq_pkg::cmd_t cmd
);
    import mlfq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADMIT = 8'b0000_0010,
        S_SEL   = 8'b0000_0100,
        S_SLOT  = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_BRD   = 8'b0010_0000,
        S_BWR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.run ? S_SEL : S_ADMIT;
                end
            end
            S_ADMIT: state_next = S_DONE;
            S_SEL:   state_next = sts.any_q ? S_SLOT : S_DONE;
            S_SLOT:  state_next = S_EXEC;
            S_EXEC:  state_next = sts.hit ? S_BRD : S_DONE;
            S_BRD:   state_next = sts.bmore ? S_BWR : S_DONE;
            S_BWR:   state_next = S_BRD;
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.take  = (state_reg == S_IDLE) && req_valid;
        cmd.admit = (state_reg == S_ADMIT);
        cmd.sel   = (state_reg == S_SEL);
        cmd.slot  = (state_reg == S_SLOT);
        cmd.exec  = (state_reg == S_EXEC);
        cmd.brd   = (state_reg == S_BRD);
        cmd.bwr   = (state_reg == S_BWR);
        cmd.load  = (state_reg == S_DONE) && sts.out_free;
    end
endmodule

// File: sv/mlfq_dp.sv
// Datapath of the scheduler: config, queue/job/free-slot RAMs, timers, result regs.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_dp #(
    parameter int LEVELS = 5,
    parameter int JOBS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mlfq_pkg::cmd_t                 cmd,
    output mlfq_pkg::sts_t                 sts,
    input  logic                           req_command,
    input  logic [mlfq_pkg::ID_W-1:0]      req_job_id,
    input  logic [mlfq_pkg::LEN_W-1:0]     req_job_length,
    input  logic                           cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output logic [1:0]                     rsp_status,
    output logic [mlfq_pkg::ID_W-1:0]      rsp_run_id,
    output logic [mlfq_pkg::LVL_W-1:0]     rsp_run_level,
    output logic [mlfq_pkg::SLICE_W-1:0]   rsp_slice_time,
    output logic [mlfq_pkg::LEN_W-1:0]     rsp_remaining,
    output logic [mlfq_pkg::TIME_W-1:0]    rsp_elapsed,
    output logic                           rsp_finished,
    output logic                           rsp_demoted,
    output logic                           rsp_boosted
);
    import mlfq_pkg::*;

    localparam int SW  = $clog2(JOBS);
    localparam int CW  = $clog2(JOBS + 1);
    localparam int QAW = $clog2(LEVELS * JOBS);
    localparam int JW  = ID_W + 2 * LEN_W;

    function automatic logic [QAW-1:0] qaddr(input logic [LVL_W-1:0] l,
                                             input logic [SW-1:0] p);
        return QAW'(l) * QAW'(JOBS) + QAW'(p);
    endfunction

    function automatic logic [SW-1:0] tail_of(input logic [SW-1:0] h,
                                              input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(JOBS))
        begin
            s = s - (CW+1)'(JOBS);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] head_inc(input logic [SW-1:0] h);
        return (h == SW'(JOBS - 1)) ? '0 : h + SW'(1);
    endfunction

    // config
    logic [QT_W-1:0] quantum_reg;
    logic [AT_W-1:0] allot_reg;
    logic [BP_W-1:0] period_reg;

    // queue control
    logic [SW-1:0] head_reg [LEVELS];
    logic [SW-1:0] head_next [LEVELS];
    logic [CW-1:0] cnt_reg [LEVELS];
    logic [CW-1:0] cnt_next [LEVELS];
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] fcnt_m1;
    logic [JOBS-1:0] used_clr_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [BP_W-1:0] bcnt_reg;

    // item and slice
    logic [ID_W-1:0]  it_id_reg;
    logic [LEN_W-1:0] it_len_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [SW-1:0]    slot_reg;

    // pending result and output
    logic [1:0]         res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [LVL_W-1:0]   res_lvl_reg;
    logic [SLICE_W-1:0] res_slice_reg;
    logic [LEN_W-1:0]   res_rem_reg;
    logic [TIME_W-1:0]  res_elapsed_reg;
    logic               res_fin_reg;
    logic               res_dem_reg;
    logic               res_boost_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [LVL_W-1:0]   out_lvl_reg;
    logic [SLICE_W-1:0] out_slice_reg;
    logic [LEN_W-1:0]   out_rem_reg;
    logic [TIME_W-1:0]  out_elapsed_reg;
    logic               out_fin_reg;
    logic               out_dem_reg;
    logic               out_boost_reg;

    // RAM ports
    logic           q_we;
    logic [QAW-1:0] q_waddr;
    logic [SW-1:0]  q_wdata;
    logic [QAW-1:0] q_raddr;
    logic [SW-1:0]  q_rdata;
    logic           j_we;
    logic [SW-1:0]  j_waddr;
    logic [JW-1:0]  j_wdata;
    logic [JW-1:0]  j_rdata;
    logic           s_we;
    logic [SW-1:0]  s_rdata;

    // combinational
    logic [LVL_W-1:0]   sel_lvl;
    logic               any_q;
    logic [LVL_W-1:0]   bsrc;
    logic               bmore;
    logic               full;
    logic [SW-1:0]      new_slot;
    logic [ID_W-1:0]    j_id;
    logic [LEN_W-1:0]   j_rem;
    logic [LEN_W-1:0]   j_used;
    logic [LEN_W-1:0]   used_eff;
    logic [SLICE_W-1:0] q8;
    logic [SLICE_W-1:0] q_eff;
    logic [LEN_W-1:0]   allot;
    logic [SLICE_W-1:0] grant;
    logic [LEN_W:0]     used_sum;
    logic [LEN_W-1:0]   used_new;
    logic [LEN_W-1:0]   rem_new;
    logic               fin;
    logic               dem;
    logic [LVL_W-1:0]   tgt;
    logic [BP_W:0]      bsum;
    logic [BP_W-1:0]    bnew;
    logic               hit;

    always_comb
    begin
        any_q   = 1'b0;
        sel_lvl = '0;
        bmore   = 1'b0;
        bsrc    = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                any_q   = 1'b1;
                sel_lvl = LVL_W'(l);
                if (l != 0)
                begin
                    bmore = 1'b1;
                    bsrc  = LVL_W'(l);
                end
            end
        end
    end

    assign full     = (fresh_reg == CW'(JOBS)) && (fcnt_reg == '0);
    assign fcnt_m1  = fcnt_reg - CW'(1);
    assign new_slot = (fresh_reg == CW'(JOBS)) ? s_rdata : fresh_reg[SW-1:0];

    assign {j_id, j_rem, j_used} = j_rdata;
    assign used_eff = used_clr_reg[slot_reg] ? '0 : j_used;

    always_comb
    begin
        case (lvl_reg)
            3'd0:    q8 = quantum_reg[7:0];
            3'd1:    q8 = quantum_reg[15:8];
            3'd2:    q8 = quantum_reg[23:16];
            3'd3:    q8 = quantum_reg[31:24];
            default: q8 = quantum_reg[39:32];
        endcase
        case (lvl_reg)
            3'd0:    allot = allot_reg[15:0];
            3'd1:    allot = allot_reg[31:16];
            3'd2:    allot = allot_reg[47:32];
            default: allot = allot_reg[63:48];
        endcase
    end

    assign q_eff    = (q8 == '0) ? SLICE_W'(1) : q8;
    assign grant    = (j_rem < LEN_W'(q_eff)) ? j_rem[SLICE_W-1:0] : q_eff;
    assign used_sum = (LEN_W+1)'(used_eff) + (LEN_W+1)'(grant);
    assign used_new = used_sum[LEN_W] ? '1 : used_sum[LEN_W-1:0];
    assign rem_new  = j_rem - LEN_W'(grant);
    assign fin      = (rem_new == '0);
    assign dem      = !fin && (lvl_reg < LVL_W'(LEVELS - 1)) && (used_new >= allot);
    assign tgt      = dem ? lvl_reg + LVL_W'(1) : lvl_reg;
    assign bsum     = (BP_W+1)'(bcnt_reg) + (BP_W+1)'(grant);
    assign bnew     = bsum[BP_W] ? '1 : bsum[BP_W-1:0];
    assign hit      = (bnew >= period_reg);

    always_comb
    begin
        sts.run      = req_command;
        sts.any_q    = any_q;
        sts.hit      = hit;
        sts.bmore    = bmore;
        sts.out_free = !out_valid_reg || rsp_ready;
    end

    // RAM port selection
    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = qaddr('0, tail_of(head_reg[0], cnt_reg[0]));
        q_wdata = new_slot;
        if (cmd.admit && !full)
        begin
            q_we = 1'b1;
        end
        else if (cmd.exec && !fin)
        begin
            q_we    = 1'b1;
            q_waddr = qaddr(tgt, tail_of(head_reg[tgt], cnt_reg[tgt]));
            q_wdata = slot_reg;
        end
        else if (cmd.bwr)
        begin
            q_we    = 1'b1;
            q_wdata = q_rdata;
        end
        q_raddr = cmd.sel ? qaddr(sel_lvl, head_reg[sel_lvl]) : qaddr(bsrc, head_reg[bsrc]);

        j_we    = (cmd.admit && !full) || cmd.exec;
        j_waddr = cmd.exec ? slot_reg : new_slot;
        j_wdata = cmd.exec ? {j_id, rem_new, (dem ? LEN_W'(0) : used_new)}
                           : {it_id_reg, it_len_reg, LEN_W'(0)};
        s_we    = cmd.exec && fin;
    end

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            cnt_next[l]  = cnt_reg[l];
            if (cmd.sel && any_q && (sel_lvl == LVL_W'(l)))
            begin
                head_next[l] = head_inc(head_reg[l]);
                cnt_next[l]  = cnt_reg[l] - CW'(1);
            end
            if (cmd.brd && bmore && (bsrc == LVL_W'(l)))
            begin
                head_next[l] = head_inc(head_reg[l]);
                cnt_next[l]  = cnt_reg[l] - CW'(1);
            end
            if (cmd.exec && !fin && (tgt == LVL_W'(l)))
            begin
                cnt_next[l] = cnt_reg[l] + CW'(1);
            end
            if (l == 0 && ((cmd.admit && !full) || cmd.bwr))
            begin
                cnt_next[l] = cnt_reg[l] + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= QUANTUM_RST;
            allot_reg     <= ALLOT_RST;
            period_reg    <= PERIOD_RST;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            fresh_reg     <= '0;
            fcnt_reg      <= '0;
            used_clr_reg  <= '0;
            elapsed_reg   <= '0;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_QUANTUM)
            begin
                quantum_reg <= cfg_data[QT_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_ALLOT)
            begin
                allot_reg <= cfg_data[AT_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_PERIOD)
            begin
                period_reg <= cfg_data[BP_W-1:0];
            end
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
            if (cmd.admit && !full)
            begin
                if (fresh_reg != CW'(JOBS))
                begin
                    fresh_reg <= fresh_reg + CW'(1);
                end
                else
                begin
                    fcnt_reg <= fcnt_m1;
                end
                used_clr_reg[new_slot] <= 1'b0;
            end
            if (cmd.exec)
            begin
                if (fin)
                begin
                    fcnt_reg <= fcnt_reg + CW'(1);
                end
                elapsed_reg <= elapsed_reg + TIME_W'(grant);
                bcnt_reg    <= hit ? '0 : bnew;
                if (hit)
                begin
                    used_clr_reg <= '1;
                end
                else
                begin
                    used_clr_reg[slot_reg] <= 1'b0;
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            it_id_reg  <= req_job_id;
            it_len_reg <= req_job_length;
        end
        if (cmd.sel)
        begin
            lvl_reg <= sel_lvl;
        end
        if (cmd.slot)
        begin
            slot_reg <= q_rdata;
        end
        if (cmd.admit)
        begin
            res_status_reg  <= full ? ST_REJECT : ST_ADMIT;
            res_id_reg      <= it_id_reg;
            res_lvl_reg     <= '0;
            res_slice_reg   <= '0;
            res_rem_reg     <= it_len_reg;
            res_elapsed_reg <= elapsed_reg;
            res_fin_reg     <= 1'b0;
            res_dem_reg     <= 1'b0;
            res_boost_reg   <= 1'b0;
        end
        if (cmd.sel && !any_q)
        begin
            res_status_reg  <= ST_IDLE;
            res_id_reg      <= '0;
            res_lvl_reg     <= '0;
            res_slice_reg   <= '0;
            res_rem_reg     <= '0;
            res_elapsed_reg <= elapsed_reg;
            res_fin_reg     <= 1'b0;
            res_dem_reg     <= 1'b0;
            res_boost_reg   <= 1'b0;
        end
        if (cmd.exec)
        begin
            res_status_reg  <= ST_RAN;
            res_id_reg      <= j_id;
            res_lvl_reg     <= lvl_reg;
            res_slice_reg   <= grant;
            res_rem_reg     <= rem_new;
            res_elapsed_reg <= elapsed_reg + TIME_W'(grant);
            res_fin_reg     <= fin;
            res_dem_reg     <= dem;
            res_boost_reg   <= hit;
        end
        if (cmd.load)
        begin
            out_status_reg  <= res_status_reg;
            out_id_reg      <= res_id_reg;
            out_lvl_reg     <= res_lvl_reg;
            out_slice_reg   <= res_slice_reg;
            out_rem_reg     <= res_rem_reg;
            out_elapsed_reg <= res_elapsed_reg;
            out_fin_reg     <= res_fin_reg;
            out_dem_reg     <= res_dem_reg;
            out_boost_reg   <= res_boost_reg;
        end
    end

    mlfq_ram #(.WIDTH(SW), .DEPTH(LEVELS * JOBS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mlfq_ram #(.WIDTH(JW), .DEPTH(JOBS)) u_job_ram (
        .clk   (clk),
        .we    (j_we),
        .waddr (j_waddr),
        .wdata (j_wdata),
        .raddr (q_rdata),
        .rdata (j_rdata)
    );

    mlfq_ram #(.WIDTH(SW), .DEPTH(JOBS)) u_free_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (fcnt_reg[SW-1:0]),
        .wdata (slot_reg),
        .raddr (fcnt_m1[SW-1:0]),
        .rdata (s_rdata)
    );

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_run_id     = out_id_reg;
    assign rsp_run_level  = out_lvl_reg;
    assign rsp_slice_time = out_slice_reg;
    assign rsp_remaining  = out_rem_reg;
    assign rsp_elapsed    = out_elapsed_reg;
    assign rsp_finished   = out_fin_reg;
    assign rsp_demoted    = out_dem_reg;
    assign rsp_boosted    = out_boost_reg;
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of mlfq_scheduler_core: a scoreboard class predicts every result.
// Depends on mlfq_pkg, mlfq_in_if and mlfq_out_if.
module tb_top;
    import mlfq_pkg::*;

    typedef struct {
        status_t     status;
        bit [15:0]   run_id;
        bit [2:0]    run_level;
        bit [7:0]    slice_time;
        bit [15:0]   remaining;
        bit [31:0]   elapsed;
        bit          finished;
        bit          demoted;
        bit          boosted;
    } sched_result_t;

    localparam int NLVL   = 5;
    localparam int NSLOT  = 16;
    localparam bit CMD_ADMIT = 1'b0;
    localparam bit CMD_RUN   = 1'b1;
    localparam int CYCLE_LIMIT = 600000;

    class sched_scoreboard;
        bit [QT_W-1:0] quanta;
        bit [AT_W-1:0] allots;
        bit [BP_W-1:0] period;
        bit [15:0]     slot_id[NSLOT];
        bit [15:0]     slot_rem[NSLOT];
        bit [15:0]     slot_used[NSLOT];
        bit            slot_free[NSLOT];
        int            level_q[NLVL][$];
        bit [31:0]     clock_now;
        int unsigned   boost_acc;
        sched_result_t pending_q[$];
        int            errors;

        function void init();
            quanta = QUANTUM_RST;
            allots = ALLOT_RST;
            period = PERIOD_RST;
            foreach (slot_free[i]) slot_free[i] = 1'b1;
            clock_now = '0;
            boost_acc = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
            if (idx == CFG_QUANTUM) quanta = val[QT_W-1:0];
            else if (idx == CFG_ALLOT) allots = val;
            else if (idx == CFG_PERIOD) period = val[BP_W-1:0];
        endfunction

        function void note_item(bit command, bit [15:0] id, bit [15:0] len);
            sched_result_t r;
            int slot, lvl, moved;
            int unsigned qn, g, used;
            r = '{ST_ADMIT, 16'd0, 3'd0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0};
            if (command == CMD_ADMIT)
            begin
                slot = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (slot < 0 && slot_free[i]) slot = i;
                r.run_id = id;
                r.remaining = len;
                if (slot < 0) r.status = ST_REJECT;
                else
                begin
                    slot_free[slot] = 1'b0;
                    slot_id[slot] = id;
                    slot_rem[slot] = len;
                    slot_used[slot] = '0;
                    level_q[0] = {level_q[0], slot};
                end
            end
            else
            begin
                lvl = -1;
                for (int l = 0; l < NLVL; l++)
                    if (lvl < 0 && level_q[l].size() != 0) lvl = l;
                if (lvl < 0) r.status = ST_IDLE;
                else
                begin
                    slot = level_q[lvl].pop_front();
                    qn = 32'((quanta >> (8 * lvl)) & 40'hFF);
                    if (qn == 0) qn = 1;
                    g = (slot_rem[slot] < qn) ? slot_rem[slot] : qn;
                    used = slot_used[slot] + g;
                    if (used > 16'hFFFF) used = 16'hFFFF;
                    slot_rem[slot] = 16'(slot_rem[slot] - g);
                    slot_used[slot] = 16'(used);
                    clock_now = clock_now + g;
                    boost_acc = boost_acc + g;
                    if (boost_acc > 16'hFFFF) boost_acc = 16'hFFFF;
                    r.status = ST_RAN;
                    r.run_id = slot_id[slot];
                    r.run_level = 3'(lvl);
                    r.slice_time = 8'(g);
                    r.remaining = slot_rem[slot];
                    if (slot_rem[slot] == 0)
                    begin
                        slot_free[slot] = 1'b1;
                        r.finished = 1'b1;
                    end
                    else if (lvl < NLVL - 1 &&
                             used >= ((allots >> (16 * lvl)) & 64'hFFFF))
                    begin
                        slot_used[slot] = '0;
                        level_q[lvl + 1] = {level_q[lvl + 1], slot};
                        r.demoted = 1'b1;
                    end
                    else
                        level_q[lvl] = {level_q[lvl], slot};
                    if (boost_acc >= period)
                    begin
                        for (int l = 1; l < NLVL; l++)
                            while (level_q[l].size() != 0)
                            begin
                                moved = level_q[l].pop_front();
                                level_q[0] = {level_q[0], moved};
                            end
                        foreach (slot_used[i]) slot_used[i] = '0;
                        boost_acc = 0;
                        r.boosted = 1'b1;
                    end
                end
            end
            r.elapsed = clock_now;
            pending_q = {pending_q, r};
        endfunction

        function void check_result(sched_result_t a);
            sched_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("result with no item pending: status %0d id %0d", a.status, a.run_id);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.run_id !== e.run_id)
            begin
                $error("run_id exp %0d got %0d", e.run_id, a.run_id); errors++;
            end
            if (a.run_level !== e.run_level)
            begin
                $error("run_level exp %0d got %0d", e.run_level, a.run_level); errors++;
            end
            if (a.slice_time !== e.slice_time)
            begin
                $error("slice_time exp %0d got %0d", e.slice_time, a.slice_time); errors++;
            end
            if (a.remaining !== e.remaining)
            begin
                $error("remaining exp %0d got %0d", e.remaining, a.remaining); errors++;
            end
            if (a.elapsed !== e.elapsed)
            begin
                $error("elapsed exp %0d got %0d", e.elapsed, a.elapsed); errors++;
            end
            if (a.finished !== e.finished)
            begin
                $error("finished exp %0d got %0d", e.finished, a.finished); errors++;
            end
            if (a.demoted !== e.demoted)
            begin
                $error("demoted exp %0d got %0d", e.demoted, a.demoted); errors++;
            end
            if (a.boosted !== e.boosted)
            begin
                $error("boosted exp %0d got %0d", e.boosted, a.boosted); errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mlfq_in_if  req ();
    mlfq_out_if rsp ();

    mlfq_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sched_scoreboard sb;
    bit calm;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        sb = new();
        sb.init();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        sched_result_t a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            a.status = status_t'(rsp.status);
            a.run_id = rsp.run_id;
            a.run_level = rsp.run_level;
            a.slice_time = rsp.slice_time;
            a.remaining = rsp.remaining;
            a.elapsed = rsp.elapsed;
            a.finished = rsp.finished;
            a.demoted = rsp.demoted;
            a.boosted = rsp.boosted;
            sb.check_result(a);
        end
    end

    task automatic send(bit command, bit [15:0] id, bit [15:0] len);
        req.valid <= 1'b1;
        req.command <= command;
        req.job_id <= id;
        req.job_length <= len;
        do @(posedge clk); while (!req.ready);
        sb.note_item(command, id, len);
        if (!calm && $urandom_range(99) < 24)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_items(int n, int admit_pct);
        bit [15:0] len;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < admit_pct)
            begin
                case ($urandom_range(19))
                    0: len = 16'($urandom_range(0, 16'hFFFF));
                    1, 2: len = 16'($urandom_range(100, 1000));
                    default: len = 16'($urandom_range(1, 60));
                endcase
                send(CMD_ADMIT, 16'($urandom_range(0, 16'hFFFF)), len);
            end
            else
                send(CMD_RUN, 16'($urandom_range(0, 16'hFFFF)),
                     16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = CFG_QUANTUM;
        cfg_data = '0;
        req.valid = 1'b0;
        req.command = 1'b0;
        req.job_id = '0;
        req.job_length = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        // directed: idle run, fill past full, extremes of fields
        send(CMD_RUN, 16'h0000, 16'h0000);
        send(CMD_ADMIT, 16'h0000, 16'h0001);
        send(CMD_ADMIT, 16'hFFFF, 16'hFFFF);
        send(CMD_ADMIT, 16'h1234, 16'h0000);
        for (int i = 3; i < 17; i++)
            send(CMD_ADMIT, 16'(16'hA000 + i), 16'(5 + i));
        for (int i = 0; i < 6; i++)
            send(CMD_RUN, 16'hFFFF, 16'hFFFF);
        drain();

        // all quanta zero, tiny allotments, zero boost period
        write_reg(CFG_QUANTUM, '0);
        write_reg(CFG_ALLOT, 64'h0001_0001_0001_0001);
        write_reg(CFG_PERIOD, 64'd0);
        random_items(60, 30);
        drain();

        // maximal settings; receiver long hold while sender keeps offering
        write_reg(CFG_QUANTUM, 64'hFF_FFFF_FFFF);
        write_reg(CFG_ALLOT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PERIOD, 64'hFFFF);
        hold_req++;
        random_items(150, 40);
        drain();

        write_reg(CFG_QUANTUM, 64'(QUANTUM_RST));
        write_reg(CFG_ALLOT, ALLOT_RST);
        write_reg(CFG_PERIOD, 64'(PERIOD_RST));
        calm = 1'b1;
        random_items(150, 35);
        calm = 1'b0;
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_QUANTUM, {$urandom, $urandom});
            write_reg(CFG_ALLOT, {16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(1, 80)),
                                  16'($urandom_range(1, 80)), 16'($urandom_range(1, 80))});
            write_reg(CFG_PERIOD, 64'($urandom_range(1, 300)));
            if (p == 1) hold_req++;
            random_items(130, 30 + 5 * p);
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
